[hw/rtl/lpft_pkg.sv]
// Shared widths, constants and types for the laser point frame transform.
`timescale 1ns / 1ps

package lpft_pkg;

	localparam int BeamsPerSensorDef = 15;
	localparam int FracBitsDef       = 12;

	localparam int CoordW = 16;             // point and frame coordinates
	localparam int RangeW = 15;             // range gate register
	localparam int LimW   = 2 * RangeW;     // squared range limit
	localparam int SegW   = 2;
	localparam int XfW    = CoordW + 2;     // transformed coordinate before clamping
	localparam int SqW    = 2 * XfW;        // one squared coordinate

	localparam logic [RangeW-1:0] RangeReset = RangeW'(20480);

	// mounting distances in units of 1e-5 m
	localparam int MountSideX  = 1800;
	localparam int MountSideY  = 8990;
	localparam int MountFrontX = 5620;
	localparam int MountScale  = 100000;

	typedef enum logic [SegW-1:0] {
		SEG_RIGHT = 2'd0,
		SEG_FRONT = 2'd1,
		SEG_LEFT  = 2'd2,
		SEG_DONE  = 2'd3     // beam past the last sensor
	} seg_t;

endpackage

[hw/rtl/lpft_point_if.sv]
// Input channel: one raw laser point per word.
`timescale 1ns / 1ps

interface lpft_point_if import lpft_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     first_of_scan;
	logic signed [CoordW-1:0] point_x;
	logic signed [CoordW-1:0] point_y;

	modport source (output valid, first_of_scan, point_x, point_y, input ready);
	modport sink   (input valid, first_of_scan, point_x, point_y, output ready);
endinterface

[hw/rtl/lpft_frame_if.sv]
// Output channel: one robot-frame point per word.
`timescale 1ns / 1ps

interface lpft_frame_if import lpft_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [CoordW-1:0] frame_x;
	logic signed [CoordW-1:0] frame_y;
	logic        [SegW-1:0]   sensor_segment;

	modport source (output valid, frame_x, frame_y, sensor_segment, input ready);
	modport sink   (input valid, frame_x, frame_y, sensor_segment, output ready);
endinterface

[hw/rtl/lpft_mount_xform.sv]
// Per-sensor quarter turn and mounting offset into the robot frame.
`timescale 1ns / 1ps

module lpft_mount_xform import lpft_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDef
) (
	input  seg_t                     seg,
	input  logic signed [CoordW-1:0] point_x,
	input  logic signed [CoordW-1:0] point_y,
	output logic signed [XfW-1:0]    tx,
	output logic signed [XfW-1:0]    ty
);

	// offsets rounded to nearest at FRAC_BITS
	localparam int OffSideXInt  = ((MountSideX  << FRAC_BITS) + MountScale / 2) / MountScale;
	localparam int OffSideYInt  = ((MountSideY  << FRAC_BITS) + MountScale / 2) / MountScale;
	localparam int OffFrontXInt = ((MountFrontX << FRAC_BITS) + MountScale / 2) / MountScale;

	localparam logic signed [XfW-1:0] OffSideX  = XfW'(OffSideXInt);
	localparam logic signed [XfW-1:0] OffSideY  = XfW'(OffSideYInt);
	localparam logic signed [XfW-1:0] OffFrontX = XfW'(OffFrontXInt);

	logic signed [XfW-1:0] px_e;
	logic signed [XfW-1:0] py_e;

	assign px_e = XfW'(point_x);
	assign py_e = XfW'(point_y);

	always_comb begin
		case (seg)
			SEG_RIGHT: begin
				tx = py_e - OffSideX;
				ty = -px_e - OffSideY;
			end
			SEG_FRONT: begin
				tx = px_e + OffFrontX;
				ty = py_e;
			end
			SEG_LEFT: begin
				tx = -py_e - OffSideX;
				ty = px_e + OffSideY;
			end
			default: begin
				tx = '0;
				ty = '0;
			end
		endcase
	end

endmodule

[hw/rtl/laser_point_frame_transform.sv]
// Top level: beam tracking, frame transform, range gate and output register.
//
//  channel  | dir | word
//  ---------+-----+--------------------------------------------------
//  points   | in  | first_of_scan, point_x, point_y
//  frames   | out | frame_x, frame_y, sensor_segment
//  cfg      | in  | cfg_we, cfg_wdata = range gate (no read-back)
//
//  One word per clock while frames.ready stays high; an accepted word passes the
//  input stage, the squaring stage and the range compare into the output register.
//  Two 18x18 squarers in the middle stage set the cycle.
//  Reset clears the beam tracker, stage valids and sets the range gate to 5.0 m.
//  A stalled output holds the pipe back one stage at a time; dropped and
//  out-of-range points leave bubbles that are squeezed out by later words.
`timescale 1ns / 1ps

module laser_point_frame_transform import lpft_pkg::*; #(
	parameter int BEAMS_PER_SENSOR = BeamsPerSensorDef,
	parameter int FRAC_BITS        = FracBitsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [RangeW-1:0] cfg_wdata,
	lpft_point_if.sink        points,
	lpft_frame_if.source      frames
);

	localparam int IdxW = (BEAMS_PER_SENSOR > 1) ? $clog2(BEAMS_PER_SENSOR) : 1;
	localparam logic [IdxW-1:0] IdxLast = IdxW'(BEAMS_PER_SENSOR - 1);

	function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [XfW-1:0] v);
		logic signed [XfW-1:0] hi;
		logic signed [XfW-1:0] lo;
		hi = XfW'({1'b0, {(CoordW-1){1'b1}}});
		lo = -hi - XfW'(1);
		if (v > hi)
			sat_coord = {1'b0, {(CoordW-1){1'b1}}};
		else if (v < lo)
			sat_coord = {1'b1, {(CoordW-1){1'b0}}};
		else
			sat_coord = v[CoordW-1:0];
	endfunction

	// squared range limit, worked out when the register is written
	logic [LimW-1:0] lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LimW'(RangeReset) * LimW'(RangeReset);
		end else if (cfg_we) begin
			lim_q <= LimW'(cfg_wdata) * LimW'(cfg_wdata);
		end
	end

	// handshake chain
	logic v_s1, v_s2, out_v_q;
	logic s1_ld, s2_ld, out_ld, accept;

	assign out_ld       = !out_v_q || frames.ready;
	assign s2_ld        = !v_s2 || out_ld;
	assign s1_ld        = !v_s1 || s2_ld;
	assign points.ready = s1_ld;
	assign accept       = points.valid && s1_ld;

	// beam tracker: sensor segment and beam within it
	seg_t            seg_q, seg_cur, seg_nxt;
	logic [IdxW-1:0] idx_q, idx_cur, idx_nxt;

	always_comb begin
		seg_cur = points.first_of_scan ? SEG_RIGHT : seg_q;
		idx_cur = points.first_of_scan ? '0 : idx_q;
		seg_nxt = seg_cur;
		idx_nxt = idx_cur;
		if (seg_cur != SEG_DONE) begin
			if (idx_cur == IdxLast) begin
				idx_nxt = '0;
				case (seg_cur)
					SEG_RIGHT: seg_nxt = SEG_FRONT;
					SEG_FRONT: seg_nxt = SEG_LEFT;
					default:   seg_nxt = SEG_DONE;
				endcase
			end else begin
				idx_nxt = idx_cur + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SEG_RIGHT;
			idx_q <= '0;
		end else if (accept) begin
			seg_q <= seg_nxt;
			idx_q <= idx_nxt;
		end
	end

	// input stage
	seg_t                     seg_s1;
	logic signed [CoordW-1:0] px_s1, py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_ld) begin
			v_s1 <= accept && (seg_cur != SEG_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seg_s1 <= seg_cur;
			px_s1  <= points.point_x;
			py_s1  <= points.point_y;
		end
	end

	// transform and squares
	logic signed [XfW-1:0] tx, ty;
	logic signed [SqW-1:0] sqx, sqy;

	lpft_mount_xform #(
		.FRAC_BITS (FRAC_BITS)
	) u_xform (
		.seg     (seg_s1),
		.point_x (px_s1),
		.point_y (py_s1),
		.tx      (tx),
		.ty      (ty)
	);

	assign sqx = tx * tx;
	assign sqy = ty * ty;

	seg_t                     seg_s2;
	logic signed [CoordW-1:0] fx_s2, fy_s2;
	logic        [SqW-1:0]    sqx_s2, sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_ld) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ld && v_s1) begin
			seg_s2 <= seg_s1;
			fx_s2  <= sat_coord(tx);
			fy_s2  <= sat_coord(ty);
			sqx_s2 <= unsigned'(sqx);
			sqy_s2 <= unsigned'(sqy);
		end
	end

	// range gate on the exact sum, strict less-than
	logic [SqW:0] r2;
	logic         in_range;

	assign r2       = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign in_range = r2 < (SqW+1)'(lim_q);

	logic signed [CoordW-1:0] frame_x_q, frame_y_q;
	seg_t                     seg_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_ld) begin
			out_v_q <= v_s2 && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld && v_s2) begin
			frame_x_q <= fx_s2;
			frame_y_q <= fy_s2;
			seg_out_q <= seg_s2;
		end
	end

	assign frames.valid          = out_v_q;
	assign frames.frame_x        = frame_x_q;
	assign frames.frame_y        = frame_y_q;
	assign frames.sensor_segment = SegW'(seg_out_q);

endmodule

[tb/testbench.sv]
// Self-checking bench for the laser point frame transform: directed points, then random scans.
`timescale 1ns / 1ps

module testbench;
	import lpft_pkg::*;

	localparam int Beams        = BeamsPerSensorDef;
	localparam int BeamLimit    = 3 * Beams;
	// mounting offsets, rounded to nearest at the fraction width
	localparam int SideX        = ((MountSideX << FracBitsDef) + MountScale / 2) / MountScale;
	localparam int SideY        = ((MountSideY << FracBitsDef) + MountScale / 2) / MountScale;
	localparam int FrontX       = ((MountFrontX << FracBitsDef) + MountScale / 2) / MountScale;
	localparam int IdleLimit    = 2000;
	localparam int HoldCycles   = 300;
	localparam int SettleCycles = 8;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		seg_t                     seg;
	} frame_word_t;

	class frame_scoreboard;
		frame_word_t       expected_q[$];
		int                beam;
		logic [RangeW-1:0] range;
		int                errors;
		int                checked;
		int                dropped;

		function new();
			beam    = 0;
			range   = RangeReset;
			errors  = 0;
			checked = 0;
			dropped = 0;
		endfunction

		static function logic signed [CoordW-1:0] clamp16(longint v);
			if (v > 32767)
				return 16'sh7fff;
			if (v < -32768)
				return 16'sh8000;
			return CoordW'(v);
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		// accepted input word: advance the beam tracker and queue the frame it yields
		function void note_point(logic first, logic signed [CoordW-1:0] px,
				logic signed [CoordW-1:0] py);
			longint      x, y, tx, ty, lim;
			int          idx;
			seg_t        seg;
			frame_word_t w;
			x = px;
			y = py;
			if (first)
				beam = 0;
			idx = beam;
			if (beam < BeamLimit)
				beam++;
			if (idx >= BeamLimit) begin
				dropped++;
				return;
			end
			seg = seg_t'(idx / Beams);
			case (seg)
				SEG_RIGHT: begin
					tx = y - SideX;
					ty = -x - SideY;
				end
				SEG_FRONT: begin
					tx = x + FrontX;
					ty = y;
				end
				default: begin
					tx = -y - SideX;
					ty = x + SideY;
				end
			endcase
			lim = longint'(range) * longint'(range);
			if (tx * tx + ty * ty >= lim) begin
				dropped++;
				return;
			end
			w.x   = clamp16(tx);
			w.y   = clamp16(ty);
			w.seg = seg;
			expected_q.push_back(w);
		endfunction

		task check_frame(logic signed [CoordW-1:0] fx, logic signed [CoordW-1:0] fy,
				logic [SegW-1:0] seg);
			frame_word_t w;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected frame x=%0d y=%0d seg=%0d", fx, fy, seg));
				return;
			end
			w = expected_q.pop_front();
			checked++;
			if (fx !== w.x)
				report($sformatf("frame_x %0d, expected %0d", fx, w.x));
			if (fy !== w.y)
				report($sformatf("frame_y %0d, expected %0d", fy, w.y));
			if (seg !== w.seg)
				report($sformatf("sensor_segment %0d, expected %0d", seg, w.seg));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [RangeW-1:0] cfg_wdata;

	lpft_point_if points_ch();
	lpft_frame_if frames_ch();

	frame_scoreboard fsb = new();

	int points_sent = 0;
	int gen_beam    = 0;   // beam index the next non-first point will get
	int idle_cycles = 0;
	int settings    = 0;
	bit send_gaps   = 1'b1;
	bit hold_req    = 1'b0;

	laser_point_frame_transform uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.points   (points_ch),
		.frames   (frames_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic signed [CoordW-1:0] extreme_value();
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return -16'sd1;
			3: return 16'sd1;
			default: return 16'sd0;
		endcase
	endfunction

	// half the time aim at a spot around the gate and map it back into the sensor frame
	function automatic void make_point(int beam, output logic signed [CoordW-1:0] px,
			output logic signed [CoordW-1:0] py);
		int span, tx, ty, ax, ay, pick;
		pick = $urandom_range(0, 19);
		if (pick < 10 && beam < BeamLimit) begin
			span = int'(fsb.range) + int'(fsb.range) / 8 + 2;
			tx   = int'($urandom_range(0, 2 * span)) - span;
			ty   = int'($urandom_range(0, 2 * span)) - span;
			case (seg_t'(beam / Beams))
				SEG_RIGHT: begin
					ax = -ty - SideY;
					ay = tx + SideX;
				end
				SEG_FRONT: begin
					ax = tx - FrontX;
					ay = ty;
				end
				default: begin
					ax = ty - SideY;
					ay = -tx - SideX;
				end
			endcase
			px = frame_scoreboard::clamp16(ax);
			py = frame_scoreboard::clamp16(ay);
		end else if (pick < 13) begin
			px = CoordW'($urandom);
			py = CoordW'($urandom);
		end else if (pick < 16) begin
			px = extreme_value();
			py = extreme_value();
		end else begin
			px = CoordW'(int'($urandom_range(0, 4096)) - 2048);
			py = CoordW'(int'($urandom_range(0, 4096)) - 2048);
		end
	endfunction

	task automatic send_point(logic first, logic signed [CoordW-1:0] px,
			logic signed [CoordW-1:0] py);
		if (send_gaps && $urandom_range(0, 1) == 1) begin
			points_ch.valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
		points_ch.valid         <= 1'b1;
		points_ch.first_of_scan <= first;
		points_ch.point_x       <= px;
		points_ch.point_y       <= py;
		do @(posedge clk); while (!points_ch.ready);
		points_sent++;
		if (first)
			gen_beam = 0;
		if (gen_beam < BeamLimit)
			gen_beam++;
	endtask

	// a well-formed scan marks only its first word; a noisy run flags words at random
	task automatic send_scan(int len, bit noisy);
		logic signed [CoordW-1:0] px, py;
		logic                     first;
		for (int i = 0; i < len; i++) begin
			first = noisy ? ($urandom_range(0, 7) == 0) : (i == 0);
			make_point(first ? 0 : gen_beam, px, py);
			send_point(first, px, py);
		end
	endtask

	task automatic run_random(int target);
		int stop_at, len;
		stop_at = points_sent + target;
		while (points_sent < stop_at) begin
			send_gaps = $urandom_range(0, 9) >= 3;
			if ($urandom_range(0, 4) != 0) begin
				case ($urandom_range(0, 9))
					0, 1:    len = $urandom_range(1, BeamLimit - 1);
					2:       len = $urandom_range(BeamLimit + 1, BeamLimit + 15);
					default: len = BeamLimit;
				endcase
				send_scan(len, 1'b0);
			end else begin
				send_scan($urandom_range(1, 20), 1'b1);
			end
		end
		points_ch.valid <= 1'b0;
	endtask

	// register write only once the pipe has drained
	task automatic set_range(logic [RangeW-1:0] value);
		while (fsb.expected_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		fsb.range = value;
		settings++;
	endtask

	always @(posedge clk) begin : monitor
		if (arst_n) begin
			if (points_ch.valid && points_ch.ready)
				fsb.note_point(points_ch.first_of_scan, points_ch.point_x, points_ch.point_y);
			if (frames_ch.valid && frames_ch.ready)
				fsb.check_frame(frames_ch.frame_x, frames_ch.frame_y, frames_ch.sensor_segment);
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (points_ch.valid && points_ch.ready) || (frames_ch.valid && frames_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("no word accepted for %0d cycles", IdleLimit);
			$display("testbench failed");
			$finish;
		end
	end

	initial begin : frame_sink
		int stall, hold_left, calm_left;
		bit calm;
		stall     = 0;
		hold_left = 0;
		calm_left = 0;
		calm      = 1'b0;
		frames_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HoldCycles;
			end
			if (calm_left == 0) begin
				calm      = $urandom_range(0, 2) == 0;
				calm_left = $urandom_range(50, 200);
			end
			calm_left--;
			if (hold_left > 0) begin
				hold_left--;
				frames_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				frames_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				stall = gap_len() - 1;
				frames_ch.ready <= 1'b0;
			end else begin
				frames_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [RangeW-1:0] ranges [8];
		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_wdata               <= '0;
		points_ch.valid         <= 1'b0;
		points_ch.first_of_scan <= 1'b0;
		points_ch.point_x       <= '0;
		points_ch.point_y       <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed points under the reset range, all on the right sensor
		send_point(1'b1, 16'sd0, 16'sd0);
		send_point(1'b0, -16'sd368, 16'sd74);       // lands on the origin
		send_point(1'b0, -16'sd368, 16'sd20553);    // just inside the gate
		send_point(1'b0, -16'sd368, 16'sd20554);    // exactly on the gate
		send_point(1'b0, -16'sd368, -16'sd20405);
		send_point(1'b0, -16'sd368, -16'sd20406);
		send_point(1'b0, 16'sh7fff, 16'sh7fff);
		send_point(1'b0, 16'sh8000, 16'sh8000);
		send_point(1'b0, 16'sh8000, 16'sh7fff);
		send_point(1'b0, 16'sh7fff, 16'sh8000);
		send_point(1'b0, 16'sd0, 16'sh7fff);
		send_point(1'b0, -16'sd1, -16'sd1);
		send_point(1'b1, 16'sd20111, 16'sd74);      // scan restarted mid-scan
		send_point(1'b0, 16'sh5555, -16'sh2aab);
		points_ch.valid <= 1'b0;

		ranges = '{15'd32767, 15'd0, 15'd1, RangeW'($urandom_range(2, 32766)), 15'd20480,
				15'd32766, RangeW'($urandom_range(100, 4000)), 15'd16384};
		foreach (ranges[p]) begin
			set_range(ranges[p]);
			// long output hold at the widest gate so the pipe backs up
			if (p == 0)
				hold_req = 1'b1;
			run_random(ranges[p] == 0 ? 50 : 155);
		end

		while (fsb.expected_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		$display("covered %0d points under %0d range settings incl. 0 and 32767",
				points_sent, settings + 1);
		$display("%0d frame words checked, %0d points dropped or gated, %0d mismatches",
				fsb.checked, fsb.dropped, fsb.errors);
		if (fsb.errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
